>>> src/kpdc_pkg.sv
// ----------------------------------------------------------------------------
// kpdc_pkg - key press duration classifier shared types
// Payload structs, config port geometry, register indexes, reset values and press kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package kpdc_pkg;

  // Config port geometry
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HOLD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd3;

  // Config reset values
  localparam logic [15:0] DEBOUNCE_RST    = 16'd20;
  localparam logic [15:0] MIN_HOLD_RST    = 16'd10;
  localparam logic [31:0] SHORT_LIMIT_RST = 32'd500;
  localparam logic [31:0] TIMEOUT_RST     = 32'd3000;

  // Press kind codes
  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  typedef struct packed {
    logic [1:0]  key_index;
    logic [31:0] edge_time;
  } kpdc_in_t;

  typedef struct packed {
    logic [1:0] press_key;
    logic       press_kind;
  } kpdc_out_t;

endpackage : kpdc_pkg

`default_nettype wire

>>> src/key_press_duration_classifier.sv
// ----------------------------------------------------------------------------
// key_press_duration_classifier - debounced short/long press detector
// Takes timestamped key edges, debounces per key, pairs press and release
// and reports each hold as a short or long press.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake                | payload
//   --------+-----+--------------------------+-------------------------------
//   in      | in  | in_valid_i / in_stall_o  | in_data_i  (key_index, edge_time)
//   out     | out | out_valid_o / out_stall_i| out_data_o (press_key, press_kind)
//   cfg     | in  | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// From input transaction to result: an input register, then a classify stage
// that reads and updates the per-key state and loads the result register. One
// transaction per cycle is sustained unless the result stalls, with no
// forwarding, since per-key state is touched only in the classify stage. Reset
// clears key state and loads config reset values. A stalled result holds both
// stages; the input register still takes a transaction while it is empty.
//
`default_nettype none

module key_press_duration_classifier #(
  parameter int unsigned NUM_KEYS  = 4,
  parameter int unsigned TICK_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,

  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire kpdc_pkg::kpdc_in_t                  in_data_i,

  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output kpdc_pkg::kpdc_out_t                      out_data_o,

  input  wire logic                                cfg_we_i,
  input  wire logic [kpdc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [kpdc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  // Compare width covers both the tick counters and the 32-bit limits
  localparam int unsigned CMP_W  = (TICK_BITS > 32) ? TICK_BITS : 32;
  // Wide enough to compare any lane number against the key field
  localparam int unsigned LANE_W = 8;

  // ---------------- config registers ----------------
  logic [15:0] debounce_q, min_hold_q;
  logic [31:0] short_limit_q, timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= kpdc_pkg::DEBOUNCE_RST;
      min_hold_q    <= kpdc_pkg::MIN_HOLD_RST;
      short_limit_q <= kpdc_pkg::SHORT_LIMIT_RST;
      timeout_q     <= kpdc_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kpdc_pkg::CFG_DEBOUNCE:    debounce_q    <= cfg_wdata_i[15:0];
        kpdc_pkg::CFG_MIN_HOLD:    min_hold_q    <= cfg_wdata_i[15:0];
        kpdc_pkg::CFG_SHORT_LIMIT: short_limit_q <= cfg_wdata_i;
        kpdc_pkg::CFG_TIMEOUT:     timeout_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic               s1_valid_q;
  kpdc_pkg::kpdc_in_t s1_data_q;
  logic               out_valid_q;
  kpdc_pkg::kpdc_out_t out_data_q;
  logic               adv;      // classify stage may move this cycle
  logic               s1_load;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_data_q <= in_data_i;
    end
  end

  // ---------------- per-key state ----------------
  logic [NUM_KEYS-1:0]  expect_rel_q;
  logic [NUM_KEYS-1:0]  pending_q;
  logic [TICK_BITS-1:0] last_stamp_q  [NUM_KEYS];
  logic [TICK_BITS-1:0] start_stamp_q [NUM_KEYS];

  // ---------------- classify ----------------
  logic [NUM_KEYS-1:0]  hit;
  logic                 key_ok;
  logic [TICK_BITS-1:0] now;
  logic [TICK_BITS-1:0] sel_last, sel_start;
  logic                 sel_expect, sel_pending;
  logic [TICK_BITS-1:0] gap, hold;
  logic                 debounce_ok, take, hold_in_band, emit;
  logic                 kind;

  always_comb begin
    sel_last    = '0;
    sel_start   = '0;
    sel_expect  = 1'b0;
    sel_pending = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      hit[k] = (LANE_W'(s1_data_q.key_index) == LANE_W'(k));
      if (hit[k]) begin
        sel_last    = last_stamp_q[k];
        sel_start   = start_stamp_q[k];
        sel_expect  = expect_rel_q[k];
        sel_pending = pending_q[k];
      end
    end
  end

  assign key_ok = |hit;   // keys at or beyond NUM_KEYS are ignored
  assign now    = TICK_BITS'(s1_data_q.edge_time);

  // Differences wrap modulo 2^TICK_BITS
  assign gap         = now - sel_last;
  assign debounce_ok = CMP_W'(gap) >= CMP_W'(debounce_q);
  assign take        = s1_valid_q && adv && key_ok && debounce_ok;

  assign hold         = now - sel_start;
  assign hold_in_band = (CMP_W'(hold) >= CMP_W'(min_hold_q)) &&
                        ((CMP_W'(hold) < CMP_W'(short_limit_q)) ||
                         (CMP_W'(hold) < CMP_W'(timeout_q)));
  assign kind = (CMP_W'(hold) < CMP_W'(short_limit_q)) ? kpdc_pkg::KIND_SHORT
                                                        : kpdc_pkg::KIND_LONG;
  // A result only on a release that closes a recorded press
  assign emit = take && sel_expect && sel_pending && hold_in_band;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_rel_q <= '0;
      pending_q    <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        last_stamp_q[k]  <= '0;
        start_stamp_q[k] <= '0;
      end
    end else if (take) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (hit[k]) begin
          last_stamp_q[k] <= now;
          if (!expect_rel_q[k]) begin
            // press edge; an earlier pending start is kept
            expect_rel_q[k] <= 1'b1;
            if (!pending_q[k]) begin
              pending_q[k]     <= 1'b1;
              start_stamp_q[k] <= now;
            end
          end else begin
            // release edge
            expect_rel_q[k]  <= 1'b0;
            pending_q[k]     <= 1'b0;
            start_stamp_q[k] <= '0;
          end
        end
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q.press_key  <= s1_data_q.key_index;
      out_data_q.press_kind <= kind;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // Press bookkeeping: a recorded press and an expected release go together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == expect_rel_q)
    else $error("kpdc: pending and expect_release diverged");

  // Input only stalls when the input register holds a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("kpdc: input stalled with empty input register");

  // A reported key is always a real key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (LANE_W'(out_data_q.press_key) < LANE_W'(NUM_KEYS)))
    else $error("kpdc: result for out-of-range key");

  // A new result follows a transaction in the classify stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(s1_valid_q))
    else $error("kpdc: result without a classified transaction");
`endif

endmodule : key_press_duration_classifier

`default_nettype wire

>>> tb/tb_key_press_duration_classifier.sv
// ----------------------------------------------------------------------------
// tb_key_press_duration_classifier - self-checking regression
// Drives timestamped key edges through the classifier under random input
// and output back-pressure, predicts every short/long press from a local
// per-key debounce and hold model, and checks each result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_key_press_duration_classifier;

  localparam int unsigned KEYS         = 4;
  localparam int unsigned DRAIN_CYCLES = 8;   // two-stage pipe plus margin
  localparam int unsigned RUN_LIMIT    = 400000;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT-facing signals. Every driven signal starts at a known value.
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  kpdc_pkg::kpdc_in_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  kpdc_pkg::kpdc_out_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [kpdc_pkg::CFG_IDX_W-1:0]  cfg_idx   = kpdc_pkg::CFG_DEBOUNCE;
  logic [kpdc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  key_press_duration_classifier dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Local copy of the block: config registers and per-key state.
  // --------------------------------------------------------------------------
  logic [15:0] cfg_debounce    = kpdc_pkg::DEBOUNCE_RST;
  logic [15:0] cfg_min_hold    = kpdc_pkg::MIN_HOLD_RST;
  logic [31:0] cfg_short_limit = kpdc_pkg::SHORT_LIMIT_RST;
  logic [31:0] cfg_timeout     = kpdc_pkg::TIMEOUT_RST;

  bit          want_release [KEYS];   // next accepted edge is a release
  bit [31:0]   last_stamp   [KEYS];   // time of last accepted edge
  bit          press_open   [KEYS];   // press recorded, waiting on release
  bit [31:0]   press_stamp  [KEYS];   // start time of the recorded press

  kpdc_pkg::kpdc_out_t press_expected_q [$];  // classified presses not yet seen
  kpdc_pkg::kpdc_in_t  edge_q [$];            // edges waiting for the driver

  int unsigned error_count   = 0;
  int unsigned edges_queued  = 0;
  bit          in_taken      = 1'b0;  // input transaction at last rising edge
  bit          calm          = 1'b0;  // no idling or stalls in the final part
  int unsigned send_gap      = 0;
  int unsigned stall_left    = 0;
  bit [31:0]   key_clock [KEYS];      // next press time per key for stimulus
  kpdc_pkg::kpdc_out_t want;

  // One accepted edge through the debounce / press-release model. A result
  // is queued only for holds in [min_hold, short) or [short, timeout).
  task automatic classify_edge(input kpdc_pkg::kpdc_in_t e);
    logic [1:0]  k;
    logic [31:0] now;
    logic [31:0] since;
    logic [31:0] hold;
    kpdc_pkg::kpdc_out_t r;
    k     = e.key_index;
    now   = e.edge_time;
    if (int'(k) >= KEYS) return;
    since = now - last_stamp[k];
    if (since < {16'd0, cfg_debounce}) return;   // bounce, dropped
    last_stamp[k] = now;
    if (!want_release[k]) begin
      want_release[k] = 1'b1;
      if (!press_open[k]) begin
        press_open[k]  = 1'b1;
        press_stamp[k] = now;
      end
      return;
    end
    want_release[k] = 1'b0;
    if (!press_open[k]) begin
      press_stamp[k] = '0;                         // stray release clears key
      return;
    end
    hold           = now - press_stamp[k];         // wraps mod 2^32
    press_open[k]  = 1'b0;
    press_stamp[k] = '0;
    if (hold < {16'd0, cfg_min_hold}) return;      // glitch
    r.press_key = k;
    if (hold < cfg_short_limit) begin
      r.press_kind = kpdc_pkg::KIND_SHORT;
      press_expected_q.push_back(r);
    end else if (hold < cfg_timeout) begin
      r.press_kind = kpdc_pkg::KIND_LONG;
      press_expected_q.push_back(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample at the rising edge. Config writes, result check, and
  // prediction for each input transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          kpdc_pkg::CFG_DEBOUNCE:    cfg_debounce    = cfg_wdata[15:0];
          kpdc_pkg::CFG_MIN_HOLD:    cfg_min_hold    = cfg_wdata[15:0];
          kpdc_pkg::CFG_SHORT_LIMIT: cfg_short_limit = cfg_wdata;
          kpdc_pkg::CFG_TIMEOUT:     cfg_timeout     = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (press_expected_q.size() == 0) begin
          $error("unexpected result: press_key %0d press_kind %0d",
                 out_data.press_key, out_data.press_kind);
          error_count++;
        end else begin
          want = press_expected_q.pop_front();
          if (out_data.press_key !== want.press_key) begin
            $error("press_key: expected %0d, actual %0d",
                   want.press_key, out_data.press_key);
            error_count++;
          end
          if (out_data.press_kind !== want.press_kind) begin
            $error("press_kind: expected %0d, actual %0d",
                   want.press_kind, out_data.press_kind);
            error_count++;
          end
        end
      end
      in_taken = in_valid && !in_stall;
      if (in_taken) classify_edge(in_data);
    end else begin
      in_taken = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: inputs change at the falling edge. A new edge is presented only
  // once the previous one went through; random gaps follow some transactions.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (edge_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= edge_q.pop_front();
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure in random bursts, none once calm.
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left  = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 7);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_edge(input logic [1:0] k, input logic [31:0] t);
    kpdc_pkg::kpdc_in_t e;
    e.key_index = k;
    e.edge_time = t;
    edge_q.push_back(e);
    edges_queued++;
  endtask

  // Register write, one cycle of enable, driven on the falling edge.
  task automatic write_reg(input logic [kpdc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kpdc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] deb, input logic [15:0] mn,
                                input logic [31:0] sh, input logic [31:0] tmo);
    write_reg(kpdc_pkg::CFG_DEBOUNCE,    {16'd0, deb});
    write_reg(kpdc_pkg::CFG_MIN_HOLD,    {16'd0, mn});
    write_reg(kpdc_pkg::CFG_SHORT_LIMIT, sh);
    write_reg(kpdc_pkg::CFG_TIMEOUT,     tmo);
  endtask

  // Let everything queued go through, all results arrive, and the pipe empty.
  task automatic wait_drained();
    while (edge_q.size() != 0 || in_valid) @(posedge clk);
    while (press_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] span(input logic [31:0] lo, input logic [31:0] hi);
    if (hi <= lo) return lo;
    return $urandom_range(hi - 1, lo);
  endfunction

  // Hold duration aimed at the classification bands of the current settings.
  function automatic logic [31:0] pick_hold();
    logic [31:0] mn;
    logic [31:0] lo;
    mn = {16'd0, cfg_min_hold};
    lo = (mn > {16'd0, cfg_debounce}) ? mn : {16'd0, cfg_debounce};
    case ($urandom_range(0, 9))
      0:       return span(0, mn);
      1, 2, 3: return span(lo, cfg_short_limit);
      4, 5:    return span(cfg_short_limit, cfg_timeout);
      6:       return cfg_timeout + $urandom_range(0, 4000);
      7, 8: begin
        case ($urandom_range(0, 5))
          0:       return mn - 1;
          1:       return mn;
          2:       return cfg_short_limit - 1;
          3:       return cfg_short_limit;
          4:       return cfg_timeout - 1;
          default: return cfg_timeout;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Move a key's stimulus clock past its last edge; now and then jump anywhere
  // so the whole timestamp range, wrap included, gets exercised.
  task automatic advance_key(input logic [1:0] k, input logic [31:0] t);
    if ($urandom_range(0, 7) == 0) key_clock[k] = $urandom();
    else key_clock[k] = t + cfg_debounce + $urandom_range(0, 4000);
  endtask

  task automatic queue_press_release();
    logic [1:0]  k;
    logic [31:0] t;
    logic [31:0] h;
    k = 2'($urandom_range(0, 3));
    t = key_clock[k];
    h = pick_hold();
    queue_edge(k, t);
    if (cfg_debounce > 1 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) queue_edge(k, t + $urandom_range(1, cfg_debounce - 1));
    end
    queue_edge(k, t + h);
    if (cfg_debounce > 1 && $urandom_range(0, 5) == 0)
      queue_edge(k, t + h + $urandom_range(1, cfg_debounce - 1));
    advance_key(k, t + h);
  endtask

  // Two keys held at once, releases interleaved.
  task automatic queue_overlap();
    logic [1:0]  ka;
    logic [1:0]  kb;
    logic [31:0] ta;
    logic [31:0] tk;
    logic [31:0] ha;
    logic [31:0] hb;
    ka = 2'($urandom_range(0, 3));
    kb = ka + 2'($urandom_range(1, 3));
    ta = key_clock[ka];
    tk = key_clock[kb];
    ha = pick_hold();
    hb = pick_hold();
    queue_edge(ka, ta);
    queue_edge(kb, tk);
    queue_edge(ka, ta + ha);
    queue_edge(kb, tk + hb);
    advance_key(ka, ta + ha);
    advance_key(kb, tk + hb);
  endtask

  // Mostly complete press/release pairs; some lone edges that break the
  // press/release alternation.
  task automatic queue_random(input int unsigned n);
    int unsigned stop;
    logic [1:0]  k;
    stop = edges_queued + n;
    while (edges_queued < stop) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          k = 2'($urandom_range(0, 3));
          queue_edge(k, ($urandom_range(0, 1) != 0) ? $urandom() :
                        key_clock[k] + $urandom_range(0, 100));
          advance_key(k, key_clock[k] + 100);
        end
        2: begin
          k = 2'($urandom_range(0, 3));
          queue_edge(k, key_clock[k]);
          advance_key(k, key_clock[k]);
        end
        3, 4, 5, 6: queue_overlap();
        default:    queue_press_release();
      endcase
    end
  endtask

  // Directed edges under the reset settings: near-reset bounce, bounce inside
  // a hold, both band edges, timeout edge, wrapped hold, all-ones timestamp.
  task automatic queue_directed();
    queue_edge(2'd0, 32'd5);            // within debounce of time zero
    queue_edge(2'd0, 32'd100);
    queue_edge(2'd0, 32'd110);          // bounce
    queue_edge(2'd0, 32'd600);          // hold 500, long
    queue_edge(2'd1, 32'd1000);
    queue_edge(2'd1, 32'd1499);         // hold 499, short
    queue_edge(2'd2, 32'd2000);
    queue_edge(2'd2, 32'd4999);         // hold 2999, long
    queue_edge(2'd3, 32'hFFFF_FFF0);
    queue_edge(2'd3, 32'h0000_0100);    // wrapped hold, short
    queue_edge(2'd0, 32'd10000);
    queue_edge(2'd0, 32'd13000);        // hold at timeout, nothing
    queue_edge(2'd1, 32'd20000);
    queue_edge(2'd1, 32'd20020);        // hold equal to debounce, short
    queue_edge(2'd2, 32'hFFFF_FFFF);
    queue_edge(2'd2, 32'h7FFF_FFFF);    // huge hold, nothing
    queue_edge(2'd1, 32'd30000);        // press never released
    queue_edge(2'd1, 32'd30005);        // bounce on it
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < KEYS; k++) key_clock[k] = 32'd50000 + 32'(k) * 32'd7919;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_directed();
    wait_drained();

    // Glitch band needs min_hold above debounce.
    write_reg(kpdc_pkg::CFG_DEBOUNCE, 32'd0);
    write_reg(kpdc_pkg::CFG_MIN_HOLD, 32'd50);
    queue_edge(2'd0, 32'd40000);
    queue_edge(2'd0, 32'd40049);        // hold 49, glitch
    queue_edge(2'd0, 32'd40049);        // same stamp, zero debounce passes
    queue_edge(2'd0, 32'd40099);        // hold 50, short
    wait_drained();

    // All-zero settings: nothing can classify.
    apply_settings(16'd0, 16'd0, 32'd0, 32'd0);
    queue_random(100);
    wait_drained();

    // All-ones settings.
    apply_settings(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(150);
    wait_drained();

    // Every hold below the all-ones timeout is long.
    apply_settings(16'd0, 16'd0, 32'd0, 32'hFFFF_FFFF);
    queue_random(150);
    wait_drained();

    // Random mid-range settings; timeout may land below the short limit.
    begin
      logic [15:0] deb;
      logic [15:0] mn;
      logic [31:0] sh;
      deb = 16'($urandom_range(0, 300));
      mn  = 16'($urandom_range(0, 600));
      sh  = mn + $urandom_range(0, 2000);
      apply_settings(deb, mn, sh, ($urandom_range(0, 5) == 0) ?
                     32'($urandom_range(0, 600)) : sh + $urandom_range(0, 5000));
    end
    queue_random(120);
    wait_drained();                     // sender holds off until all results are in
    queue_random(130);
    wait_drained();

    // Last part at reset settings, full rate on both sides.
    calm = 1'b1;
    apply_settings(kpdc_pkg::DEBOUNCE_RST, kpdc_pkg::MIN_HOLD_RST,
                   kpdc_pkg::SHORT_LIMIT_RST, kpdc_pkg::TIMEOUT_RST);
    queue_random(200);
    wait_drained();

    if (error_count == 0) begin
      $display("key_press_duration_classifier regression: pass");
    end else begin
      $display("key_press_duration_classifier regression: fail");
    end
    $finish;
  end

  // Watchdog: a missing result or a hung handshake ends here.
  initial begin
    #RUN_LIMIT;
    $display("key_press_duration_classifier regression: fail");
    $finish;
  end

endmodule : tb_key_press_duration_classifier

`default_nettype wire

>>> sim.f
src/kpdc_pkg.sv
src/key_press_duration_classifier.sv
tb/tb_key_press_duration_classifier.sv
